// ===== src/mmul_pkg.sv =====
// Shared types, constants and a helper function of the integer matrix multiply core.
package mmul_pkg;

	// Largest matrix dimension held on chip.
	localparam int MAX_DIM = 32;
	// Bits of a row or column index.
	localparam int IDX_W = $clog2(MAX_DIM);
	// Bits of a dimension register: it holds zero up to MAX_DIM itself.
	localparam int DIM_W = 6;
	// Element and result width.
	localparam int DATA_W = 32;
	// One store holds MAX_DIM by MAX_DIM elements, addressed as row then column.
	localparam int ADDR_W = 2 * IDX_W;
	localparam int DEPTH = MAX_DIM * MAX_DIM;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd2;

	localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

	typedef enum logic [1:0] {
		FUNC_LOAD_A = 2'd0,
		FUNC_LOAD_B = 2'd1,
		FUNC_QUERY = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN
	} seq_state_t;

	// Commands from the sequencer to the multiply-accumulate datapath.
	typedef struct packed {
		logic clear;    // start of a query: empty the accumulator
		logic rd_valid; // a pair of elements is being read this cycle
		logic rd_last;  // that pair is the last of the dot product
		logic quick;    // give a result at once without a walk
		logic bad;      // the quick result flags an index out of range
	} mac_cmd_t;

	// Clamps a dimension register to the size of the stores.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] lim;
		lim = DIM_W'(MAX_DIM);
		return (v > lim) ? lim : v;
	endfunction

endpackage

// ===== src/mmul_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module mmul_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/mmul_seq.sv =====
// Sequencer: accepts items, steers element loads and walks the inner dimension of a query.
module mmul_seq import mmul_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        func,
	input  logic [IDX_W-1:0]  row,
	input  logic [IDX_W-1:0]  col,
	input  logic [DIM_W-1:0]  dim_m,
	input  logic [DIM_W-1:0]  dim_n,
	input  logic [DIM_W-1:0]  dim_w,
	input  logic              finish,
	output logic              busy,
	output logic              we_a,
	output logic              we_b,
	output logic [ADDR_W-1:0] waddr,
	output logic              re,
	output logic [ADDR_W-1:0] raddr_a,
	output logic [ADDR_W-1:0] raddr_b,
	output mac_cmd_t          cmd
);

	seq_state_t state_q, state_d;
	logic [IDX_W-1:0] row_q, col_q;
	logic [DIM_W-1:0] w_q;
	logic [DIM_W-1:0] k_q;
	logic             accept;
	logic             row_in_m, row_in_w, col_in_w, col_in_n;
	logic             last_k;

	assign accept = start && (state_q == ST_IDLE);
	assign row_in_m = {1'b0, row} < dim_m;
	assign row_in_w = {1'b0, row} < dim_w;
	assign col_in_w = {1'b0, col} < dim_w;
	assign col_in_n = {1'b0, col} < dim_n;
	assign last_k = (k_q == (w_q - DIM_W'(1)));

	assign busy = (state_q != ST_IDLE);
	assign waddr = {row, col};
	assign raddr_a = {row_q, k_q[IDX_W-1:0]};
	assign raddr_b = {k_q[IDX_W-1:0], col_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && func_t'(func) == FUNC_QUERY) begin
			row_q <= row;
			col_q <= col;
			w_q <= dim_w;
			k_q <= '0;
		end else if (state_q == ST_WALK) begin
			k_q <= k_q + DIM_W'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		we_a = 1'b0;
		we_b = 1'b0;
		re = 1'b0;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func_t'(func))
						FUNC_LOAD_A: we_a = row_in_m && col_in_w;
						FUNC_LOAD_B: we_b = row_in_w && col_in_n;
						FUNC_QUERY: begin
							cmd.clear = 1'b1;
							if (!(row_in_m && col_in_n)) begin
								cmd.quick = 1'b1;
								cmd.bad = 1'b1;
							end else if (dim_w == '0) begin
								cmd.quick = 1'b1;
							end else begin
								state_d = ST_WALK;
							end
						end
						default: ;
					endcase
				end
			end
			ST_WALK: begin
				re = 1'b1;
				cmd.rd_valid = 1'b1;
				cmd.rd_last = last_k;
				if (last_k) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== src/mmul_mac.sv =====
// Multiply-accumulate datapath and result register.
module mmul_mac import mmul_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_cmd_t                 cmd,
	input  logic [DATA_W-1:0]        rdata_a,
	input  logic [DATA_W-1:0]        rdata_b,
	output logic                     finish,
	output logic                     done,
	output logic signed [DATA_W-1:0] product,
	output logic                     bad_index
);

	logic              v_s1, last_s1;
	logic              v_s2, last_s2;
	logic [DATA_W-1:0] prod_s2;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] sum;
	logic              done_q;
	logic [DATA_W-1:0] product_q;
	logic              bad_q;

	assign sum = acc_q + prod_s2;
	assign finish = v_s2 && last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_valid;
			v_s2 <= v_s1;
			done_q <= finish || cmd.quick;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= cmd.rd_last;
		last_s2 <= last_s1;
		// The read data is registered inside the stores and lines up with the first stage.
		prod_s2 <= DATA_W'(rdata_a * rdata_b);
		if (cmd.clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= sum;
		end
		product_q <= finish ? sum : '0;
		bad_q <= cmd.quick && cmd.bad;
	end

	assign done = done_q;
	assign product = product_q;
	assign bad_index = bad_q;

endmodule

// ===== src/integer_matrix_multiply_core.sv =====
// Top level of the integer matrix multiply core.
//
// The core holds matrix A and matrix B in two on-chip stores of MAX_DIM by MAX_DIM
// 32-bit words and answers queries for single elements of the product A times B.
// An item is taken at a rising edge where start is high and busy is low. A load of
// an A or B element keeps busy low and the next item may follow straight away;
// a load outside the configured sizes is dropped. A query for an element inside the
// sizes walks the inner dimension through one multiply-accumulate unit fed by one
// read of each store per cycle; busy stays high through the walk and its drain, and
// the next item can be taken in the cycle in which the result is shown. A query
// outside the sizes, or one with an inner size of zero, gives its result in the
// next cycle and keeps busy low.
// Each result beat is shown for exactly one cycle, marked by done; the receiver has
// no means of holding it, so it must capture product and bad_index in that cycle.
// Products and the running sum wrap modulo 2^32. An element must be loaded before a
// query reads it: the stores are not cleared at reset. Size registers above MAX_DIM
// act as MAX_DIM, and they may only be rewritten while the core is idle.
module integer_matrix_multiply_core import mmul_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DIM_W-1:0]         cfg_data,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               func,
	input  logic [IDX_W-1:0]         row,
	input  logic [IDX_W-1:0]         col,
	input  logic signed [DATA_W-1:0] value,
	output logic                     done,
	output logic signed [DATA_W-1:0] product,
	output logic                     bad_index
);

	logic [DIM_W-1:0]  rows_a_q, cols_b_q, inner_size_q;
	logic [DIM_W-1:0]  dim_m, dim_n, dim_w;
	logic              we_a, we_b, re;
	logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
	logic [DATA_W-1:0] wdata, rdata_a, rdata_b;
	logic              finish;
	mac_cmd_t          cmd;

	// Size registers; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= DIM_RESET;
			cols_b_q <= DIM_RESET;
			inner_size_q <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROWS_A: rows_a_q <= cfg_data;
				CFG_COLS_B: cols_b_q <= cfg_data;
				CFG_INNER_SIZE: inner_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sizes as the stores see them.
	assign dim_m = eff_dim(rows_a_q);
	assign dim_n = eff_dim(cols_b_q);
	assign dim_w = eff_dim(inner_size_q);

	assign wdata = value;

	// The sequencer drives the stores; busy keeps loads away from a query in flight,
	// so a store is never written and read at the same entry in one walk.
	mmul_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.func    (func),
		.row     (row),
		.col     (col),
		.dim_m   (dim_m),
		.dim_n   (dim_n),
		.dim_w   (dim_w),
		.finish  (finish),
		.busy    (busy),
		.we_a    (we_a),
		.we_b    (we_b),
		.waddr   (waddr),
		.re      (re),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.cmd     (cmd)
	);

	// Store of A, one word per element, addressed row then column.
	mmul_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	// Store of B, laid out the same way.
	mmul_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	// Multiply, accumulate and present the result beat.
	mmul_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.finish    (finish),
		.done      (done),
		.product   (product),
		.bad_index (bad_index)
	);

endmodule

// ===== src/mmul_checker.sv =====
// Port-level checks of the integer matrix multiply core and their binding.
module mmul_checker import mmul_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     cfg_we,
	input logic [CFG_IDX_W-1:0]     cfg_index,
	input logic [DIM_W-1:0]         cfg_data,
	input logic                     start,
	input logic                     busy,
	input logic [1:0]               func,
	input logic [IDX_W-1:0]         row,
	input logic [IDX_W-1:0]         col,
	input logic signed [DATA_W-1:0] value,
	input logic                     done,
	input logic signed [DATA_W-1:0] product,
	input logic                     bad_index
);

	// A load or an unused code never produces a result beat.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (func != FUNC_QUERY) |=> !done)
		else $error("result beat after a load item");

	// A query either starts a walk or answers in the next cycle.
	a_query_answered: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (func == FUNC_QUERY) |=> busy || done)
		else $error("query neither started nor answered");

	// The end of a walk always delivers its result beat.
	a_walk_ends_in_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("walk ended without a result beat");

	// No result beat appears while a walk is in progress.
	a_no_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result beat while busy");

	// An out-of-range query reports a zero product.
	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && bad_index |-> product == '0)
		else $error("out-of-range result with non-zero product");

endmodule

bind integer_matrix_multiply_core mmul_checker u_mmul_checker (.*);

// ===== sim/integer_matrix_multiply_core_tb.sv =====
// Self-checking testbench of the integer matrix multiply core: scripted beats, then random phases.
`timescale 1ns / 100ps

// The testbench keeps its own copy of both element stores and of the three size
// registers. Each accepted load beat updates that copy under the same bounds as the
// core. Each accepted query beat pushes the element of A times B that the core must
// return onto a queue. A monitor takes every result beat off the ports and checks it,
// field by field, against the oldest entry of that queue.
//
// The run has two parts. A short script covers the corners that can be read off by
// eye: unit sizes, extreme element values, loads and queries outside the sizes, an
// empty inner dimension, an empty row dimension, the unused function code and sizes
// above the store limit. Random phases follow. Each phase writes a fresh set of sizes
// while the core is idle, then mixes complete multiply sequences with noise.
// A complete sequence loads each A and B element that the query will read and that was
// never loaded, rewrites some of the others at random, and then queries. The noise is
// loose loads, queries at any index and the unused code. No query ever reads an
// element that was never loaded, because the core does not clear its stores at reset.
module integer_matrix_multiply_core_tb;
	import mmul_pkg::*;

	localparam int CLK_HALF = 4;
	localparam int RESET_CYCLES = 10;
	// Accepted loads and queries before the random part stops.
	localparam int ITEM_TARGET = 850;
	// A load may still be in flight when the last result has arrived.
	localparam int IDLE_SETTLE = 4;
	// Wait at the end comfortably beyond the longest query, a walk of MAX_DIM.
	localparam int DRAIN_CYCLES = 3 * MAX_DIM;
	localparam int WATCHDOG_NS = 20_000_000;
	localparam int REPORT_LIMIT = 10;
	// The function code that the core must ignore.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [DATA_W-1:0] product;
		logic              bad;
	} element_t;

	typedef enum logic {
		STEP_BEAT,
		STEP_RESIZE
	} step_kind_t;

	typedef struct packed {
		step_kind_t        kind;
		logic [1:0]        fn;
		logic [IDX_W-1:0]  r;
		logic [IDX_W-1:0]  c;
		logic [DATA_W-1:0] v;
		logic [DIM_W-1:0]  m;
		logic [DIM_W-1:0]  n;
		logic [DIM_W-1:0]  w;
		logic              typed;
		element_t          want;
	} step_t;

	localparam int SCRIPT_LEN = 29;

	// Rows with typed set carry a result that is obvious by inspection; every other
	// query row is checked against the predictor.
	step_t script [SCRIPT_LEN] = '{
		// Unit sizes: a one-element dot product of -1 by -1.
		'{STEP_RESIZE, FUNC_LOAD_A, 5'd0, 5'd0, 32'h0, 6'd1, 6'd1, 6'd1, 1'b0, '{32'h0, 1'b0}},
		'{STEP_BEAT, FUNC_LOAD_A, 5'd0, 5'd0, 32'hFFFF_FFFF, 6'd0, 6'd0, 6'd0, 1'b0, '{32'h0, 1'b0}},
		'{STEP_BEAT, FUNC_LOAD_B, 5'd0, 5'd0, 32'hFFFF_FFFF, 6'd0, 6'd0, 6'd0, 1'b0, '{32'h0, 1'b0}},
		'{STEP_BEAT, FUNC_QUERY, 5'd0, 5'd0, 32'h0, 6'd0, 6'd0, 6'd0, 1'b1, '{32'h1, 1'b0}},
		// Loads just outside each bound must be dropped.
		'{STEP_BEAT, FUNC_LOAD_A, 5'd0, 5'd1, 32'h1234_5678, 6'd0, 6'd0, 6'd0, 1'b0, '{32'h0, 1'b0}},
		'{STEP_BEAT, FUNC_LOAD_B, 5'd1, 5'd0, 32'h1234_5678, 6'd0, 6'd0, 6'd0, 1'b0, '{32'h0, 1'b0}},
		'{STEP_BEAT, FUNC_LOAD_A, 5'd1, 5'd0, 32'h8765_4321, 6'd0, 6'd0, 6'd0, 1'b0, '{32'h0, 1'b0}},
		'{STEP_BEAT, FUNC_LOAD_B, 5'd0, 5'd1, 32'h8765_4321, 6'd0, 6'd0, 6'd0, 1'b0, '{32'h0, 1'b0}},
		// Queries outside the sizes come back as zero with the error flag.
		'{STEP_BEAT, FUNC_QUERY, 5'd1, 5'd0, 32'h0, 6'd0, 6'd0, 6'd0, 1'b1, '{32'h0, 1'b1}},
		'{STEP_BEAT, FUNC_QUERY, 5'd0, 5'd1, 32'hFFFF_FFFF, 6'd0, 6'd0, 6'd0, 1'b1, '{32'h0, 1'b1}},
		'{STEP_BEAT, FUNC_QUERY, 5'd31, 5'd31, 32'h0, 6'd0, 6'd0, 6'd0, 1'b1, '{32'h0, 1'b1}},
		// The unused code gives nothing back.
		'{STEP_BEAT, FUNC_UNUSED, 5'd31, 5'd31, 32'hFFFF_FFFF, 6'd0, 6'd0, 6'd0, 1'b0, '{32'h0, 1'b0}},
		// Most negative squared wraps to zero.
		'{STEP_BEAT, FUNC_LOAD_A, 5'd0, 5'd0, 32'h8000_0000, 6'd0, 6'd0, 6'd0, 1'b0, '{32'h0, 1'b0}},
		'{STEP_BEAT, FUNC_LOAD_B, 5'd0, 5'd0, 32'h8000_0000, 6'd0, 6'd0, 6'd0, 1'b0, '{32'h0, 1'b0}},
		'{STEP_BEAT, FUNC_QUERY, 5'd0, 5'd0, 32'h0, 6'd0, 6'd0, 6'd0, 1'b1, '{32'h0, 1'b0}},
		'{STEP_BEAT, FUNC_LOAD_A, 5'd0, 5'd0, 32'h7FFF_FFFF, 6'd0, 6'd0, 6'd0, 1'b0, '{32'h0, 1'b0}},
		'{STEP_BEAT, FUNC_QUERY, 5'd0, 5'd0, 32'h0, 6'd0, 6'd0, 6'd0, 1'b0, '{32'h0, 1'b0}},
		// Two-term sum of large products, which wraps.
		'{STEP_RESIZE, FUNC_LOAD_A, 5'd0, 5'd0, 32'h0, 6'd2, 6'd2, 6'd2, 1'b0, '{32'h0, 1'b0}},
		'{STEP_BEAT, FUNC_LOAD_A, 5'd0, 5'd1, 32'h7FFF_FFFF, 6'd0, 6'd0, 6'd0, 1'b0, '{32'h0, 1'b0}},
		'{STEP_BEAT, FUNC_LOAD_B, 5'd1, 5'd0, 32'h7FFF_FFFF, 6'd0, 6'd0, 6'd0, 1'b0, '{32'h0, 1'b0}},
		'{STEP_BEAT, FUNC_QUERY, 5'd0, 5'd0, 32'h0, 6'd0, 6'd0, 6'd0, 1'b0, '{32'h0, 1'b0}},
		// Empty inner dimension: an in-range query sums nothing.
		'{STEP_RESIZE, FUNC_LOAD_A, 5'd0, 5'd0, 32'h0, 6'd2, 6'd2, 6'd0, 1'b0, '{32'h0, 1'b0}},
		'{STEP_BEAT, FUNC_QUERY, 5'd1, 5'd1, 32'h0, 6'd0, 6'd0, 6'd0, 1'b1, '{32'h0, 1'b0}},
		// No rows of A: loads vanish and every query is out of range.
		'{STEP_RESIZE, FUNC_LOAD_A, 5'd0, 5'd0, 32'h0, 6'd0, 6'd2, 6'd2, 1'b0, '{32'h0, 1'b0}},
		'{STEP_BEAT, FUNC_LOAD_A, 5'd0, 5'd0, 32'h5, 6'd0, 6'd0, 6'd0, 1'b0, '{32'h0, 1'b0}},
		'{STEP_BEAT, FUNC_QUERY, 5'd0, 5'd0, 32'h0, 6'd0, 6'd0, 6'd0, 1'b1, '{32'h0, 1'b1}},
		// Sizes beyond the stores saturate, so the far corner can be loaded.
		'{STEP_RESIZE, FUNC_LOAD_A, 5'd0, 5'd0, 32'h0, 6'd63, 6'd63, 6'd63, 1'b0, '{32'h0, 1'b0}},
		'{STEP_BEAT, FUNC_LOAD_A, 5'd31, 5'd31, 32'h1, 6'd0, 6'd0, 6'd0, 1'b0, '{32'h0, 1'b0}},
		'{STEP_BEAT, FUNC_LOAD_B, 5'd31, 5'd31, 32'hFFFF_FFFF, 6'd0, 6'd0, 6'd0, 1'b0, '{32'h0, 1'b0}}
	};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [DIM_W-1:0]         cfg_data = '0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [1:0]               func = '0;
	logic [IDX_W-1:0]         row = '0;
	logic [IDX_W-1:0]         col = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     done;
	logic signed [DATA_W-1:0] product;
	logic                     bad_index;

	// Shadow of the core: both stores, which entries hold a loaded word, and the sizes.
	logic [DATA_W-1:0] a_words [DEPTH];
	logic [DATA_W-1:0] b_words [DEPTH];
	bit                a_loaded [DEPTH];
	bit                b_loaded [DEPTH];
	logic [DIM_W-1:0]  rows_a_reg = DIM_RESET;
	logic [DIM_W-1:0]  cols_b_reg = DIM_RESET;
	logic [DIM_W-1:0]  inner_reg = DIM_RESET;

	element_t awaited_elements [$];
	int unsigned accepted_items = 0;
	int unsigned mismatches = 0;
	// When set, the sender offers beats back to back for a whole phase.
	bit back_to_back = 1'b0;

	integer_matrix_multiply_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.row       (row),
		.col       (col),
		.value     (value),
		.done      (done),
		.product   (product),
		.bad_index (bad_index)
	);

	always #CLK_HALF clk = ~clk;

	function automatic int unsigned dim_in_use(input logic [DIM_W-1:0] v);
		return (v > DIM_W'(MAX_DIM)) ? MAX_DIM : v;
	endfunction

	// Element (r, c) of A times B as the core must return it, with 32-bit wrap on every
	// product and on the running sum.
	function automatic element_t dot_product(input logic [IDX_W-1:0] r,
	                                         input logic [IDX_W-1:0] c);
		element_t          res;
		logic [DATA_W-1:0] acc;
		logic [IDX_W-1:0]  kk;
		res = '{product: '0, bad: 1'b1};
		if (r < dim_in_use(rows_a_reg) && c < dim_in_use(cols_b_reg)) begin
			acc = '0;
			for (int k = 0; k < dim_in_use(inner_reg); k++) begin
				kk = k[IDX_W-1:0];
				acc = acc + a_words[{r, kk}] * b_words[{kk, c}];
			end
			res = '{product: acc, bad: 1'b0};
		end
		return res;
	endfunction

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return '1;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'h1;
			default: return $urandom;
		endcase
	endfunction

	// Sizes lean towards small values, with the empty, unit, full and saturated cases.
	function automatic logic [DIM_W-1:0] pick_dim();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 6)
			return '0;
		else if (sel < 14)
			return DIM_W'(MAX_DIM);
		else if (sel < 18)
			return '1;
		else if (sel < 22)
			return DIM_W'($urandom_range(MAX_DIM + 1, 62));
		else if (sel < 28)
			return 6'd1;
		else if (sel < 70)
			return DIM_W'($urandom_range(2, 6));
		return DIM_W'($urandom_range(7, MAX_DIM - 1));
	endfunction

	// Mostly short gaps, some medium and a few long ones.
	function automatic int unsigned pick_gap();
		int unsigned sel;
		if (back_to_back)
			return 0;
		sel = $urandom_range(0, 99);
		if (sel < 45)
			return 0;
		else if (sel < 80)
			return $urandom_range(1, 3);
		else if (sel < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic log_error(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t ns: %s", $time, msg);
	endtask

	// Offers one beat after a random gap and holds it until the core takes it. The shadow
	// is updated at the accepting edge. Start is left high, so the caller either offers
	// the next beat in the same step or lowers start itself.
	task automatic drive_beat(input logic [1:0] f_code, input logic [IDX_W-1:0] r_idx,
	                          input logic [IDX_W-1:0] c_idx, input logic [DATA_W-1:0] v_word,
	                          input logic typed, input element_t want);
		int unsigned gap;
		int unsigned m;
		int unsigned n;
		int unsigned w;
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= f_code;
		row <= r_idx;
		col <= c_idx;
		value <= v_word;
		do @(posedge clk); while (busy);
		m = dim_in_use(rows_a_reg);
		n = dim_in_use(cols_b_reg);
		w = dim_in_use(inner_reg);
		case (f_code)
			FUNC_LOAD_A: begin
				if (r_idx < m && c_idx < w) begin
					a_words[{r_idx, c_idx}] = v_word;
					a_loaded[{r_idx, c_idx}] = 1'b1;
					accepted_items++;
				end
			end
			FUNC_LOAD_B: begin
				if (r_idx < w && c_idx < n) begin
					b_words[{r_idx, c_idx}] = v_word;
					b_loaded[{r_idx, c_idx}] = 1'b1;
					accepted_items++;
				end
			end
			FUNC_QUERY: begin
				awaited_elements.push_back(typed ? want : dot_product(r_idx, c_idx));
				accepted_items++;
			end
			default: ;
		endcase
	endtask

	// A query at (r, c). Inside the sizes, every element it reads is loaded first if it
	// never was, and with refresh set a share of the others get new random words too.
	task automatic issue_query(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
	                           input bit refresh);
		logic [IDX_W-1:0] kk;
		if (r < dim_in_use(rows_a_reg) && c < dim_in_use(cols_b_reg)) begin
			for (int k = 0; k < dim_in_use(inner_reg); k++) begin
				kk = k[IDX_W-1:0];
				if (!a_loaded[{r, kk}] || (refresh && $urandom_range(0, 2) == 0))
					drive_beat(FUNC_LOAD_A, r, kk, pick_word(), 1'b0, '0);
				if (!b_loaded[{kk, c}] || (refresh && $urandom_range(0, 2) == 0))
					drive_beat(FUNC_LOAD_B, kk, c, pick_word(), 1'b0, '0);
			end
		end
		drive_beat(FUNC_QUERY, r, c, $urandom, 1'b0, '0);
	endtask

	// Lowers start in the current step and waits until every awaited result has come
	// and any trailing load has settled.
	task automatic wait_idle();
		start <= 1'b0;
		while (awaited_elements.size() != 0) @(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Writes all three size registers on consecutive edges, so the write enable is
	// raised and lowered only once.
	task automatic set_sizes(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] n,
	                         input logic [DIM_W-1:0] w);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ROWS_A;
		cfg_data <= m;
		@(posedge clk);
		rows_a_reg = m;
		cfg_index <= CFG_COLS_B;
		cfg_data <= n;
		@(posedge clk);
		cols_b_reg = n;
		cfg_index <= CFG_INNER_SIZE;
		cfg_data <= w;
		@(posedge clk);
		inner_reg = w;
		cfg_we <= 1'b0;
	endtask

	// Every result beat is shown for one cycle only, so it is taken at the edge that
	// ends that cycle and checked straight away.
	always @(posedge clk) begin
		element_t want;
		if (arst_n && done) begin
			if (awaited_elements.size() == 0) begin
				log_error($sformatf("result beat with nothing awaited: product %h bad_index %b",
					product, bad_index));
			end else begin
				want = awaited_elements.pop_front();
				if (product !== want.product)
					log_error($sformatf("product: expected %h, got %h", want.product, product));
				if (bad_index !== want.bad)
					log_error($sformatf("bad_index: expected %b, got %b", want.bad, bad_index));
			end
		end
	end

	initial begin
		int unsigned sel;
		int unsigned phase_len;
		int unsigned m;
		int unsigned n;
		int unsigned w;
		int unsigned lim_r;
		int unsigned lim_c;
		logic [1:0] f_code;
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] c;
		bit first_phase;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			if (script[i].kind == STEP_RESIZE) begin
				wait_idle();
				set_sizes(script[i].m, script[i].n, script[i].w);
			end else begin
				drive_beat(script[i].fn, script[i].r, script[i].c, script[i].v,
					script[i].typed, script[i].want);
			end
		end

		// Random phases. The first one runs at full size and is kept short, since each of
		// its queries may load a whole row of A and a whole column of B; the rest draw
		// their sizes. Each boundary waits for every awaited result before the sizes
		// change, and a phase stops early once enough items have been taken.
		first_phase = 1'b1;
		while (accepted_items < ITEM_TARGET) begin
			wait_idle();
			back_to_back = ($urandom_range(0, 4) == 0);
			if (first_phase) begin
				set_sizes(DIM_W'(MAX_DIM), DIM_W'(MAX_DIM), DIM_W'(MAX_DIM));
				phase_len = $urandom_range(3, 6);
			end else begin
				set_sizes(pick_dim(), pick_dim(), pick_dim());
				phase_len = $urandom_range(20, 80);
			end
			first_phase = 1'b0;
			m = dim_in_use(rows_a_reg);
			n = dim_in_use(cols_b_reg);
			w = dim_in_use(inner_reg);
			for (int s = 0; s < phase_len && accepted_items < ITEM_TARGET; s++) begin
				sel = $urandom_range(0, 99);
				if (sel < 50 && m != 0 && n != 0) begin
					// A complete multiply sequence inside the sizes.
					issue_query(IDX_W'($urandom_range(0, m - 1)),
						IDX_W'($urandom_range(0, n - 1)), 1'b1);
				end else if (sel < 75) begin
					// A loose load, usually inside the bounds of its matrix.
					f_code = ($urandom_range(0, 1) == 0) ? FUNC_LOAD_A : FUNC_LOAD_B;
					lim_r = (f_code == FUNC_LOAD_A) ? m : w;
					lim_c = (f_code == FUNC_LOAD_A) ? w : n;
					if (lim_r != 0 && lim_c != 0 && $urandom_range(0, 9) < 7) begin
						r = IDX_W'($urandom_range(0, lim_r - 1));
						c = IDX_W'($urandom_range(0, lim_c - 1));
					end else begin
						r = IDX_W'($urandom_range(0, MAX_DIM - 1));
						c = IDX_W'($urandom_range(0, MAX_DIM - 1));
					end
					drive_beat(f_code, r, c, pick_word(), 1'b0, '0);
				end else if (sel < 95) begin
					issue_query(IDX_W'($urandom_range(0, MAX_DIM - 1)),
						IDX_W'($urandom_range(0, MAX_DIM - 1)), 1'b0);
				end else begin
					drive_beat(FUNC_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom,
						1'b0, '0);
				end
			end
		end

		start <= 1'b0;
		while (awaited_elements.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("integer_matrix_multiply_core regression: pass");
		else
			$display("integer_matrix_multiply_core regression: fail");
		$finish;
	end

	// A hang anywhere, including a result that never comes, ends the run here.
	initial begin
		#(WATCHDOG_NS);
		$display("integer_matrix_multiply_core regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
src/mmul_pkg.sv
src/mmul_ram.sv
src/mmul_seq.sv
src/mmul_mac.sv
src/integer_matrix_multiply_core.sv
src/mmul_checker.sv
sim/integer_matrix_multiply_core_tb.sv
